/* design/apq_pkg.sv */
package apq_pkg;

    // Field widths of one request and one response transaction.
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;

    // Default number of slots.
    localparam int DEPTH_DEF = 8;

    // Request opcodes.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Response status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } state_t;

    // Running best entry that walks down the row of slots during a scan.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } probe_t;

endpackage

/* design/apq_req_if.sv */
interface apq_req_if
    import apq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              action;
    logic [ID_W-1:0]   entry_id;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, output action, output entry_id, output priority_req,
                    input ready);
    modport sink   (input valid, input action, input entry_id, input priority_req,
                    output ready);
endinterface

/* design/apq_rsp_if.sv */
interface apq_rsp_if
    import apq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_id;
    logic [PRIO_W-1:0]   out_priority;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output out_id, output out_priority,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_id, input out_priority,
                    input occupancy, output ready);
endinterface

/* design/apq_cell.sv */
module apq_cell
    import apq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int IDX_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  cnt,
    input  logic              ins_en,
    input  logic [ID_W-1:0]   ins_id,
    input  logic [PRIO_W-1:0] ins_prio,
    input  logic              shift_en,
    input  logic [IDX_W-1:0]  best_idx,
    input  logic [ID_W-1:0]   nbr_id,
    input  logic [PRIO_W-1:0] nbr_prio,
    output logic [ID_W-1:0]   id,
    output logic [PRIO_W-1:0] prio,
    input  probe_t            probe_in,
    input  logic [IDX_W-1:0]  probe_idx_in,
    output probe_t            probe_out,
    output logic [IDX_W-1:0]  probe_idx_out
);

    localparam logic [CNT_W-1:0] MY_POS   = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT_POS = CNT_W'(IDX + 1);
    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(IDX);

    logic [ID_W-1:0]   id_reg, id_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    probe_t            probe_reg, probe_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic              occupied;
    logic              take;

    // A slot takes the running best when none is found yet, else only when
    // strictly larger, so ties keep the earlier entry.
    always_comb
    begin
        occupied = cnt > MY_POS;
        take     = probe_in.valid && occupied
                   && (!probe_in.found || (prio_reg > probe_in.prio));
        if (take)
        begin
            probe_next = '{valid: 1'b1, found: 1'b1, prio: prio_reg, id: id_reg};
            pidx_next  = MY_IDX;
        end
        else
        begin
            probe_next = probe_in;
            pidx_next  = probe_idx_in;
        end
    end

    // Insert fills slot cnt; slots from the removed entry on move up by one.
    always_comb
    begin
        id_next   = id_reg;
        prio_next = prio_reg;
        if (ins_en && (cnt == MY_POS))
        begin
            id_next   = ins_id;
            prio_next = ins_prio;
        end
        else if (shift_en && (MY_IDX >= best_idx) && (cnt > NEXT_POS))
        begin
            id_next   = nbr_id;
            prio_next = nbr_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
            pidx_reg  <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            pidx_reg  <= pidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign id            = id_reg;
    assign prio          = prio_reg;
    assign probe_out     = probe_reg;
    assign probe_idx_out = pidx_reg;

endmodule

/* design/array_priority_queue.sv */
// Latency: an insert or a remove on an empty queue shows its response in the cycle after acceptance.
// A remove on a non-empty queue answers after the scan, once the response register is free.
// Throughput: one insert per cycle while the response register is free; a remove blocks new
// requests until it answers, its scan walking the best candidate one slot per cycle down the row.
// Reset: rst_n is asynchronous, active low; it empties the queue and drops any pending response.
// Slot contents are not cleared by reset; only occupied slots are ever read.
module array_priority_queue
    import apq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    apq_req_if.sink   req,
    apq_rsp_if.source rsp
);

    localparam int               CNT_W     = $clog2(DEPTH + 1);
    localparam int               IDX_W     = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // Control state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Result of the scan, held until the response register is free.
    logic [ID_W-1:0]   best_id_reg, best_id_next;
    logic [PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;

    // Response payload.
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic [PRIO_W-1:0]   out_prio_reg, out_prio_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;

    // Handshake and control decode.
    logic rsp_free;
    logic accept;
    logic is_remove;
    logic is_full;
    logic ins_en;
    logic start_scan;
    logic scan_done;
    logic shift_en;
    logic load_rsp;

    // Row of cells.
    logic [ID_W-1:0]   cell_id   [DEPTH];
    logic [PRIO_W-1:0] cell_prio [DEPTH];
    probe_t            probe_q   [DEPTH];
    logic [IDX_W-1:0]  probe_idx [DEPTH];
    probe_t            seed;

    // The response register frees up in the same cycle its transaction completes, so a new
    // request can be taken while the previous response is being consumed.
    assign rsp_free   = !rsp_valid_reg || rsp.ready;
    assign req.ready  = (state_reg == S_IDLE) && rsp_free;
    assign accept     = req.valid && req.ready;
    assign is_remove  = req.action == ACT_REMOVE;
    assign is_full    = count_reg >= DEPTH_CNT;
    assign ins_en     = accept && !is_remove && !is_full;
    assign start_scan = accept && is_remove && (count_reg != '0);
    assign scan_done  = probe_q[DEPTH-1].valid;

    // The scan starts with an empty candidate at slot zero; each cell compares it with its own
    // entry and hands the winner to the next cell in the following cycle.
    assign seed = '{valid: start_scan, found: 1'b0, prio: '0, id: '0};

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ID_W-1:0]   nbr_id;
        logic [PRIO_W-1:0] nbr_prio;
        probe_t            p_in;
        logic [IDX_W-1:0]  p_idx_in;

        if (i == DEPTH - 1)
        begin : g_last
            assign nbr_id   = cell_id[i];
            assign nbr_prio = cell_prio[i];
        end
        else
        begin : g_mid
            assign nbr_id   = cell_id[i+1];
            assign nbr_prio = cell_prio[i+1];
        end

        if (i == 0)
        begin : g_head
            assign p_in     = seed;
            assign p_idx_in = '0;
        end
        else
        begin : g_body
            assign p_in     = probe_q[i-1];
            assign p_idx_in = probe_idx[i-1];
        end

        apq_cell #(
            .DEPTH (DEPTH),
            .IDX   (i),
            .CNT_W (CNT_W),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cnt           (count_reg),
            .ins_en        (ins_en),
            .ins_id        (req.entry_id),
            .ins_prio      (req.priority_req),
            .shift_en      (shift_en),
            .best_idx      (best_idx_reg),
            .nbr_id        (nbr_id),
            .nbr_prio      (nbr_prio),
            .id            (cell_id[i]),
            .prio          (cell_prio[i]),
            .probe_in      (p_in),
            .probe_idx_in  (p_idx_in),
            .probe_out     (probe_q[i]),
            .probe_idx_out (probe_idx[i])
        );
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start_scan)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output and datapath control.
    always_comb
    begin
        shift_en       = 1'b0;
        load_rsp       = 1'b0;
        best_id_next   = best_id_reg;
        best_prio_next = best_prio_reg;
        best_idx_next  = best_idx_reg;
        status_next    = status_reg;
        out_id_next    = out_id_reg;
        out_prio_next  = out_prio_reg;
        count_next     = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // Inserts and removes on an empty queue answer right away.
                if (accept && !start_scan)
                begin
                    load_rsp      = 1'b1;
                    out_id_next   = '0;
                    out_prio_next = '0;
                    if (is_remove)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else if (is_full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        status_next = STATUS_DONE;
                        count_next  = count_reg + 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    best_id_next   = probe_q[DEPTH-1].id;
                    best_prio_next = probe_q[DEPTH-1].prio;
                    best_idx_next  = probe_idx[DEPTH-1];
                end
            end
            S_HOLD:
            begin
                // Close the gap and publish the removed entry in the same cycle.
                if (rsp_free)
                begin
                    shift_en      = 1'b1;
                    load_rsp      = 1'b1;
                    status_next   = STATUS_DONE;
                    out_id_next   = best_id_reg;
                    out_prio_next = best_prio_reg;
                    count_next    = count_reg - 1'b1;
                end
            end
            default:
            begin
                shift_en = 1'b0;
            end
        endcase
        occ_next       = load_rsp ? OCC_W'(count_next) : occ_reg;
        rsp_valid_next = load_rsp ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_id_reg   <= best_id_next;
        best_prio_reg <= best_prio_next;
        best_idx_reg  <= best_idx_next;
        status_reg    <= status_next;
        out_id_reg    <= out_id_next;
        out_prio_reg  <= out_prio_next;
        occ_reg       <= occ_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_id       = out_id_reg;
    assign rsp.out_priority = out_prio_reg;
    assign rsp.occupancy    = occ_reg;

    // The queue never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count exceeds depth");

    // A scan is only ever running over a non-empty queue.
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (count_reg != '0))
        else $error("scan running on an empty queue");

    // Completing a remove takes exactly one entry out of the queue.
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_HOLD) && rsp_free) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove did not decrement the entry count");

    // An accepted insert into a non-full queue adds exactly one entry.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ins_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not increment the entry count");

    // The scan result always reaches the last cell with a candidate found.
    a_scan_found: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && scan_done) |-> probe_q[DEPTH-1].found)
        else $error("scan finished without a candidate");

endmodule
